/* hw/rtl/stlc_pkg.sv */
package stlc_pkg;

	localparam int unsigned IdW      = 29;
	localparam int unsigned LenW     = 4;
	localparam int unsigned PayloadW = 64;
	localparam int unsigned WordW    = 16;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned HystW    = 15;
	localparam int unsigned CfgIdxW  = 3;

	localparam logic [ByteW-1:0] OPCODE_READ_ENCODER = 8'h90;
	localparam logic [ByteW-1:0] OPCODE_READ_STATUS1 = 8'h9A;
	localparam logic [ByteW-1:0] OPCODE_TORQUE       = 8'hA1;
	localparam logic [ByteW-1:0] OPCODE_STATUS_REPLY = 8'hA0;
	localparam logic [LenW-1:0]  MIN_FRAME_LEN       = 4'd8;

	localparam logic ACTION_RX = 1'b0;
	localparam logic ACTION_TX = 1'b1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MOTOR_ID     = 3'd0,
		REG_STEER_ZERO   = 3'd1,
		REG_STEER_LO     = 3'd2,
		REG_STEER_HI     = 3'd3,
		REG_RELEASE_BAND = 3'd4,
		REG_CMD_FLOOR    = 3'd5,
		REG_CMD_CEIL     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        [IdW-1:0]   motor_id;
		logic        [WordW-1:0] steer_zero;
		logic signed [WordW-1:0] steer_lo;
		logic signed [WordW-1:0] steer_hi;
		logic        [HystW-1:0] release_band;
		logic signed [WordW-1:0] cmd_floor;
		logic signed [WordW-1:0] cmd_ceil;
	} cfg_t;

	typedef struct packed {
		logic                    action;
		logic        [IdW-1:0]   frame_id;
		logic        [LenW-1:0]  frame_len;
		logic [PayloadW-1:0]     frame_payload;
		logic signed [WordW-1:0] torque_request;
	} item_t;

	typedef struct packed {
		logic        [WordW-1:0] encoder_pos;
		logic signed [ByteW-1:0] temperature;
		logic signed [WordW-1:0] current;
		logic signed [WordW-1:0] speed;
		logic        [ByteW-1:0] error;
	} status_t;

endpackage

/* hw/rtl/steer_torque_limiter_can_frames.sv */
// Chan | Handshake             | Fields
// -----+-----------------------+----------------------------------------------------------
// in   | in_valid / in_ready   | action, frame_id, frame_len, frame_payload, torque_request
// out  | out_valid / out_ready | accept/tx/limit flags, tx_payload, steer_value, *_now status
// cfg  | cfg_valid / cfg_ready | cfg_index, cfg_data, one register per write request
//
// Each accepted request goes through the input register, then the result register;
// one request per cycle sustained while out_ready holds, set by the single input register.
// Reset clears the configuration to its defaults, the stored status and the limit flag.
// A stalled result holds the result register; the input register still takes one
// request, after which in_ready drops until out_ready frees the result register.
// Configuration writes are taken every cycle (cfg_ready is tied high).
module steer_torque_limiter_can_frames (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic        [stlc_pkg::IdW-1:0]       frame_id,
	input  logic        [stlc_pkg::LenW-1:0]      frame_len,
	input  logic        [stlc_pkg::PayloadW-1:0]  frame_payload,
	input  logic signed [stlc_pkg::WordW-1:0]     torque_request,

	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  frame_accepted,
	output logic                                  tx_valid,
	output logic        [stlc_pkg::PayloadW-1:0]  tx_payload,
	output logic                                  limit_active,
	output logic signed [stlc_pkg::WordW-1:0]     steer_value,
	output logic        [stlc_pkg::WordW-1:0]     encoder_now,
	output logic signed [stlc_pkg::ByteW-1:0]     temperature_now,
	output logic signed [stlc_pkg::WordW-1:0]     current_now,
	output logic signed [stlc_pkg::WordW-1:0]     speed_now,
	output logic        [stlc_pkg::ByteW-1:0]     error_now,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [stlc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic        [stlc_pkg::IdW-1:0]       cfg_data
);

	stlc_pkg::cfg_t    cfg;
	stlc_pkg::item_t   item_s1;
	stlc_pkg::status_t st;
	logic              valid_s1;
	logic              advance;
	logic              fire_rx;
	logic              fire_tx;
	logic              accepted;
	logic [stlc_pkg::WordW-1:0]    encoder_next;
	logic [stlc_pkg::PayloadW-1:0] torque_frame;
	logic                          limited;
	logic signed [16:0]            steer_raw;
	logic signed [stlc_pkg::WordW-1:0] steer_d;

	logic                              out_valid_q;
	logic                              frame_accepted_q;
	logic                              tx_valid_q;
	logic [stlc_pkg::PayloadW-1:0]     tx_payload_q;
	logic signed [stlc_pkg::WordW-1:0] steer_q;

	// configuration registers, written whenever a write request shows up
	assign cfg_ready = 1'b1;

	stlc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance the input register into the result register once the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign fire_rx  = advance && (item_s1.action == stlc_pkg::ACTION_RX);
	assign fire_tx  = advance && (item_s1.action == stlc_pkg::ACTION_TX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action         <= action;
			item_s1.frame_id       <= frame_id;
			item_s1.frame_len      <= frame_len;
			item_s1.frame_payload  <= frame_payload;
			item_s1.torque_request <= torque_request;
		end
	end

	// received-frame path: id and length match, opcode decode into the status store
	stlc_rx_status u_rx (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire_rx),
		.item         (item_s1),
		.motor_id     (cfg.motor_id),
		.accepted     (accepted),
		.encoder_next (encoder_next),
		.st           (st)
	);

	// torque path: limit flag, negation, clamp and command frame packing
	stlc_torque u_tq (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire_tx),
		.cfg            (cfg),
		.encoder        (st.encoder_pos),
		.torque_request (item_s1.torque_request),
		.limited        (limited),
		.tx_payload     (torque_frame)
	);

	// steer angle after this request: center minus encoder, clamped to the angle bounds;
	// the lower bound is checked first, so it wins where both bounds are exceeded
	assign steer_raw = signed'({1'b0, cfg.steer_zero}) - signed'({1'b0, encoder_next});

	always_comb begin
		if (steer_raw < signed'({cfg.steer_lo[15], cfg.steer_lo})) begin
			steer_d = cfg.steer_lo;
		end else if (steer_raw > signed'({cfg.steer_hi[15], cfg.steer_hi})) begin
			steer_d = cfg.steer_hi;
		end else begin
			steer_d = steer_raw[15:0];
		end
	end

	// result register; drop valid once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_accepted_q <= accepted;
			tx_valid_q       <= (item_s1.action == stlc_pkg::ACTION_TX);
			tx_payload_q     <= (item_s1.action == stlc_pkg::ACTION_TX) ? torque_frame : '0;
			steer_q          <= steer_d;
		end
	end

	// the status store and limit flag change only when a result is loaded, so they
	// already hold the after-request values while the result waits
	assign out_valid       = out_valid_q;
	assign frame_accepted  = frame_accepted_q;
	assign tx_valid        = tx_valid_q;
	assign tx_payload      = tx_payload_q;
	assign limit_active    = limited;
	assign steer_value     = steer_q;
	assign encoder_now     = st.encoder_pos;
	assign temperature_now = st.temperature;
	assign current_now     = st.current;
	assign speed_now       = st.speed;
	assign error_now       = st.error;

`ifndef NO_ASSERTIONS
	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(tx_valid_q && frame_accepted_q))
		else $error("result is both a sent command and an accepted frame");
	a_idle_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tx_valid_q) |-> (tx_payload_q == '0))
		else $error("command bytes present on a frame result");
	a_tx_layout: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tx_valid_q) |-> (tx_payload_q[7:0] == stlc_pkg::OPCODE_TORQUE
			&& tx_payload_q[31:8] == '0 && tx_payload_q[63:48] == '0))
		else $error("command frame layout broken");
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(tx_payload_q)
			&& $stable(steer_q)))
		else $error("stalled result changed");
`endif

endmodule

/* hw/rtl/stlc_cfg_regs.sv */
module stlc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [stlc_pkg::CfgIdxW-1:0]     wr_index,
	input  logic [stlc_pkg::IdW-1:0]         wr_data,
	output stlc_pkg::cfg_t                   cfg
);

	stlc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_id     <= 29'd321;
			cfg_q.steer_zero   <= 16'h8000;
			cfg_q.steer_lo     <= -16'sd32768;
			cfg_q.steer_hi     <= 16'sd32767;
			cfg_q.release_band <= 15'd100;
			cfg_q.cmd_floor    <= -16'sd2048;
			cfg_q.cmd_ceil     <= 16'sd2048;
		end else if (wr_en) begin
			case (wr_index)
				stlc_pkg::REG_MOTOR_ID:     cfg_q.motor_id <= wr_data;
				stlc_pkg::REG_STEER_ZERO:   cfg_q.steer_zero <= wr_data[15:0];
				stlc_pkg::REG_STEER_LO:     cfg_q.steer_lo <= signed'(wr_data[15:0]);
				stlc_pkg::REG_STEER_HI:     cfg_q.steer_hi <= signed'(wr_data[15:0]);
				stlc_pkg::REG_RELEASE_BAND: cfg_q.release_band <= wr_data[14:0];
				stlc_pkg::REG_CMD_FLOOR:    cfg_q.cmd_floor <= signed'(wr_data[15:0]);
				stlc_pkg::REG_CMD_CEIL:     cfg_q.cmd_ceil <= signed'(wr_data[15:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/stlc_rx_status.sv */
module stlc_rx_status (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  stlc_pkg::item_t             item,
	input  logic [stlc_pkg::IdW-1:0]    motor_id,
	output logic                        accepted,
	output logic [stlc_pkg::WordW-1:0]  encoder_next,
	output stlc_pkg::status_t           st
);

	stlc_pkg::status_t st_q;
	stlc_pkg::status_t st_d;
	logic [stlc_pkg::ByteW-1:0] op;
	logic upd;

	assign accepted = (item.action == stlc_pkg::ACTION_RX)
		&& (item.frame_id == motor_id)
		&& (item.frame_len >= stlc_pkg::MIN_FRAME_LEN);
	assign op  = item.frame_payload[7:0];
	assign upd = fire && accepted;

	// decode the reply opcode; unknown opcodes leave the status alone
	always_comb begin
		st_d = st_q;
		if (accepted) begin
			case (op)
				stlc_pkg::OPCODE_READ_ENCODER: begin
					st_d.encoder_pos = item.frame_payload[31:16];
				end
				stlc_pkg::OPCODE_STATUS_REPLY, stlc_pkg::OPCODE_TORQUE: begin
					st_d.temperature = signed'(item.frame_payload[15:8]);
					st_d.current     = signed'(item.frame_payload[31:16]);
					st_d.speed       = signed'(item.frame_payload[47:32]);
					st_d.encoder_pos = item.frame_payload[63:48];
				end
				stlc_pkg::OPCODE_READ_STATUS1: begin
					st_d.error = item.frame_payload[63:56];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (upd) begin
			st_q <= st_d;
		end
	end

	assign encoder_next = st_d.encoder_pos;
	assign st           = st_q;

`ifndef NO_ASSERTIONS
	a_hold_without_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(st_q))
		else $error("status changed without an accepted frame");
	a_reject_len: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.frame_len < stlc_pkg::MIN_FRAME_LEN) |=> $stable(st_q))
		else $error("short frame changed status");
	a_torque_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		(item.action == stlc_pkg::ACTION_TX) |-> !accepted)
		else $error("torque request taken as a frame");
`endif

endmodule

/* hw/rtl/stlc_torque.sv */
module stlc_torque (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  stlc_pkg::cfg_t                     cfg,
	input  logic        [stlc_pkg::WordW-1:0]  encoder,
	input  logic signed [stlc_pkg::WordW-1:0]  torque_request,
	output logic                               limited,
	output logic        [stlc_pkg::PayloadW-1:0] tx_payload
);

	logic                              limited_q;
	logic                              limited_d;
	logic signed [16:0]                pos;
	logic signed [17:0]                pos_w;
	logic signed [17:0]                min_w;
	logic signed [17:0]                max_w;
	logic signed [17:0]                lo_rel;
	logic signed [17:0]                hi_rel;
	logic                              release_ok;
	logic                              trip;
	logic signed [stlc_pkg::WordW-1:0] neg;
	logic signed [stlc_pkg::WordW-1:0] t0;
	logic signed [stlc_pkg::WordW-1:0] t1;
	logic signed [stlc_pkg::WordW-1:0] t2;

	assign pos    = signed'({1'b0, cfg.steer_zero}) - signed'({1'b0, encoder});
	assign pos_w  = {pos[16], pos};
	assign min_w  = {{2{cfg.steer_lo[15]}}, cfg.steer_lo};
	assign max_w  = {{2{cfg.steer_hi[15]}}, cfg.steer_hi};
	assign lo_rel = min_w + signed'({3'b000, cfg.release_band});
	assign hi_rel = max_w - signed'({3'b000, cfg.release_band});

	assign release_ok = (pos_w >= lo_rel) && (pos_w <= hi_rel);
	assign trip       = (pos_w < min_w) || (pos_w > max_w);
	assign limited_d  = limited_q ? !release_ok : trip;

	// flip the sign, wrapping the most negative request onto itself
	assign neg = -torque_request;
	assign t0  = limited_d ? '0 : neg;
	assign t1  = (t0 < cfg.cmd_floor) ? cfg.cmd_floor : t0;
	assign t2  = (t1 > cfg.cmd_ceil) ? cfg.cmd_ceil : t1;

	assign tx_payload = {16'h0000, t2, 24'h000000, stlc_pkg::OPCODE_TORQUE};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limited_q <= 1'b0;
		end else if (fire) begin
			limited_q <= limited_d;
		end
	end

	assign limited = limited_q;

`ifndef NO_ASSERTIONS
	a_flag_only_on_torque: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(limited_q))
		else $error("limit flag moved without a torque request");
	a_zero_when_limited: assert property (@(posedge clk) disable iff (!arst_n)
		limited_d |-> (t0 == '0))
		else $error("torque not forced to zero under limit");
	a_trip_needs_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!limited_q && !trip) |-> !limited_d)
		else $error("limit set inside range");
`endif

endmodule

/* tb/steer_torque_limiter_can_frames_tb.sv */
module steer_torque_limiter_can_frames_tb;

	// Give up well past the slowest legal run: ~1800 requests, each with a full
	// sender gap, a full receiver stall and the pipeline, plus the long hold-off.
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_WAIT    = 19;

	// Index past the end of the register map; a write there must change nothing.
	localparam logic [stlc_pkg::CfgIdxW-1:0] REG_UNUSED = 3'd7;

	localparam stlc_pkg::cfg_t RESET_CFG = '{
		motor_id:     29'd321,
		steer_zero:   16'h8000,
		steer_lo:     16'sh8000,
		steer_hi:     16'sh7FFF,
		release_band: 15'd100,
		cmd_floor:    -16'sd2048,
		cmd_ceil:     16'sd2048
	};

	typedef struct packed {
		logic                              frame_accepted;
		logic                              tx_valid;
		logic [stlc_pkg::PayloadW-1:0]     tx_payload;
		logic                              limit_active;
		logic signed [stlc_pkg::WordW-1:0] steer_value;
		stlc_pkg::status_t                 status;
	} steer_result_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic                                 action;
	logic        [stlc_pkg::IdW-1:0]      frame_id;
	logic        [stlc_pkg::LenW-1:0]     frame_len;
	logic        [stlc_pkg::PayloadW-1:0] frame_payload;
	logic signed [stlc_pkg::WordW-1:0]    torque_request;
	logic                                 out_valid;
	logic                                 out_ready;
	logic                                 frame_accepted;
	logic                                 tx_valid;
	logic        [stlc_pkg::PayloadW-1:0] tx_payload;
	logic                                 limit_active;
	logic signed [stlc_pkg::WordW-1:0]    steer_value;
	logic        [stlc_pkg::WordW-1:0]    encoder_now;
	logic signed [stlc_pkg::ByteW-1:0]    temperature_now;
	logic signed [stlc_pkg::WordW-1:0]    current_now;
	logic signed [stlc_pkg::WordW-1:0]    speed_now;
	logic        [stlc_pkg::ByteW-1:0]    error_now;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic        [stlc_pkg::CfgIdxW-1:0]  cfg_index;
	logic        [stlc_pkg::IdW-1:0]      cfg_data;

	// Shadow copy of the motor link: configuration, stored status, limit flag.
	stlc_pkg::cfg_t    shadow_cfg;
	stlc_pkg::status_t motor_shadow;
	logic              limit_shadow;
	steer_result_t     pending_results[$];

	bit          sender_pacing;
	bit          receiver_pacing;
	bit          hold_request;
	int unsigned stall_left;
	int unsigned cycle_count;
	int unsigned requests_taken;
	int unsigned results_checked;
	int unsigned frames_taken;
	int unsigned torque_zeroed;
	int unsigned cfg_writes;
	int unsigned mismatches;

	steer_torque_limiter_can_frames dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.frame_id        (frame_id),
		.frame_len       (frame_len),
		.frame_payload   (frame_payload),
		.torque_request  (torque_request),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_accepted  (frame_accepted),
		.tx_valid        (tx_valid),
		.tx_payload      (tx_payload),
		.limit_active    (limit_active),
		.steer_value     (steer_value),
		.encoder_now     (encoder_now),
		.temperature_now (temperature_now),
		.current_now     (current_now),
		.speed_now       (speed_now),
		.error_now       (error_now),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Steering position relative to center, at full precision (no 16-bit wrap).
	function automatic int steer_position();
		int c;
		int e;
		c = shadow_cfg.steer_zero;
		e = motor_shadow.encoder_pos;
		return c - e;
	endfunction

	// Advance the shadow by one request and return the result it must produce.
	function automatic steer_result_t track_steering(stlc_pkg::item_t it);
		steer_result_t                     r;
		logic [stlc_pkg::ByteW-1:0]        op;
		logic signed [stlc_pkg::WordW-1:0] neg;
		int pos;
		int t;
		int s;
		int amin;
		int amax;
		int hyst;
		int tmin;
		int tmax;
		r    = '0;
		amin = shadow_cfg.steer_lo;
		amax = shadow_cfg.steer_hi;
		hyst = shadow_cfg.release_band;
		tmin = shadow_cfg.cmd_floor;
		tmax = shadow_cfg.cmd_ceil;
		if (it.action == stlc_pkg::ACTION_RX) begin
			// Only a frame from our motor with a full eight bytes is parsed.
			if (it.frame_id == shadow_cfg.motor_id
					&& it.frame_len >= stlc_pkg::MIN_FRAME_LEN) begin
				r.frame_accepted = 1'b1;
				frames_taken++;
				op = it.frame_payload[7:0];
				if (op == stlc_pkg::OPCODE_READ_ENCODER) begin
					motor_shadow.encoder_pos = it.frame_payload[31:16];
				end else if (op == stlc_pkg::OPCODE_STATUS_REPLY
						|| op == stlc_pkg::OPCODE_TORQUE) begin
					motor_shadow.temperature = it.frame_payload[15:8];
					motor_shadow.current     = it.frame_payload[31:16];
					motor_shadow.speed       = it.frame_payload[47:32];
					motor_shadow.encoder_pos = it.frame_payload[63:48];
				end else if (op == stlc_pkg::OPCODE_READ_STATUS1) begin
					motor_shadow.error = it.frame_payload[63:56];
				end
			end
		end else begin
			// Flip to motor sign; the most negative request wraps onto itself.
			neg = -it.torque_request;
			t   = neg;
			pos = steer_position();
			if (limit_shadow) begin
				if (pos >= amin + hyst && pos <= amax - hyst)
					limit_shadow = 1'b0;
			end else if (pos < amin || pos > amax) begin
				limit_shadow = 1'b1;
			end
			if (limit_shadow) begin
				t = 0;
				torque_zeroed++;
			end
			// Lower bound first, so an inverted pair leaves the upper bound in charge.
			if (t < tmin)
				t = tmin;
			if (t > tmax)
				t = tmax;
			r.tx_valid   = 1'b1;
			r.tx_payload = {16'h0000, t[15:0], 24'h000000, stlc_pkg::OPCODE_TORQUE};
		end
		s = steer_position();
		if (s < amin)
			s = amin;
		else if (s > amax)
			s = amax;
		r.limit_active = limit_shadow;
		r.steer_value  = s[15:0];
		r.status       = motor_shadow;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Predict on every request taken and compare every result taken, both at
	// the rising edge so that they see the values from before the edge.
	always @(posedge clk) begin : scoreboard
		stlc_pkg::item_t taken;
		steer_result_t   seen;
		steer_result_t   want;
		cycle_count++;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				taken.action         = action;
				taken.frame_id       = frame_id;
				taken.frame_len      = frame_len;
				taken.frame_payload  = frame_payload;
				taken.torque_request = torque_request;
				pending_results.push_back(track_steering(taken));
				requests_taken++;
			end
			if (out_valid && out_ready) begin
				seen.frame_accepted     = frame_accepted;
				seen.tx_valid           = tx_valid;
				seen.tx_payload         = tx_payload;
				seen.limit_active       = limit_active;
				seen.steer_value        = steer_value;
				seen.status.encoder_pos = encoder_now;
				seen.status.temperature = temperature_now;
				seen.status.current     = current_now;
				seen.status.speed       = speed_now;
				seen.status.error       = error_now;
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("frame_accepted", want.frame_accepted, seen.frame_accepted);
					check_field("tx_valid", want.tx_valid, seen.tx_valid);
					check_field("tx_payload", want.tx_payload, seen.tx_payload);
					check_field("limit_active", want.limit_active, seen.limit_active);
					check_field("steer_value", want.steer_value, seen.steer_value);
					check_field("encoder_now", want.status.encoder_pos,
						seen.status.encoder_pos);
					check_field("temperature_now", want.status.temperature,
						seen.status.temperature);
					check_field("current_now", want.status.current, seen.status.current);
					check_field("speed_now", want.status.speed, seen.status.speed);
					check_field("error_now", want.status.error, seen.status.error);
				end
				results_checked++;
				// Draw how long the receiver waits before taking the next result.
				stall_left = receiver_pacing ? $urandom_range(0, MAX_WAIT) : 0;
			end
		end
	end

	// Result side: drive out_ready at the falling edge. A hold-off request
	// loads a long count here and keeps the block from draining.
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (stall_left != 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("steer_torque_limiter_can_frames: mismatch");
		$finish;
	end

	// Offer one request and hold it until taken. Call and return at a falling
	// edge; valid stays high on return so back-to-back requests never drop it.
	task automatic send_item(input stlc_pkg::item_t it);
		int unsigned gap;
		gap = sender_pacing ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		action         = it.action;
		frame_id       = it.frame_id;
		frame_len      = it.frame_len;
		frame_payload  = it.frame_payload;
		torque_request = it.torque_request;
		in_valid       = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [stlc_pkg::IdW-1:0] id,
			input logic [stlc_pkg::LenW-1:0] len,
			input logic [stlc_pkg::PayloadW-1:0] payload);
		stlc_pkg::item_t it;
		it.action         = stlc_pkg::ACTION_RX;
		it.frame_id       = id;
		it.frame_len      = len;
		it.frame_payload  = payload;
		it.torque_request = 16'($urandom);
		send_item(it);
	endtask

	task automatic send_torque(input logic signed [stlc_pkg::WordW-1:0] req);
		stlc_pkg::item_t it;
		it.action         = stlc_pkg::ACTION_TX;
		it.frame_id       = 29'($urandom);
		it.frame_len      = 4'($urandom);
		it.frame_payload  = {$urandom, $urandom};
		it.torque_request = req;
		send_item(it);
	endtask

	// Drop valid and wait until every outstanding result has come back.
	task automatic drain_requests();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [stlc_pkg::CfgIdxW-1:0] idx,
			input logic [stlc_pkg::IdW-1:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			stlc_pkg::REG_MOTOR_ID:     shadow_cfg.motor_id     = data;
			stlc_pkg::REG_STEER_ZERO:   shadow_cfg.steer_zero   = data[15:0];
			stlc_pkg::REG_STEER_LO:     shadow_cfg.steer_lo     = data[15:0];
			stlc_pkg::REG_STEER_HI:     shadow_cfg.steer_hi     = data[15:0];
			stlc_pkg::REG_RELEASE_BAND: shadow_cfg.release_band = data[14:0];
			stlc_pkg::REG_CMD_FLOOR:    shadow_cfg.cmd_floor    = data[15:0];
			stlc_pkg::REG_CMD_CEIL:     shadow_cfg.cmd_ceil     = data[15:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
		@(negedge clk);
	endtask

	// Write the whole register map while idle; the narrow registers get random
	// upper data bits half the time, which the block must ignore.
	task automatic apply_config(input stlc_pkg::cfg_t c);
		logic [31:0] junk;
		drain_requests();
		junk = $urandom_range(0, 1) ? $urandom : 32'h0;
		write_reg(stlc_pkg::REG_MOTOR_ID, c.motor_id);
		write_reg(stlc_pkg::REG_STEER_ZERO, {junk[12:0], c.steer_zero});
		write_reg(stlc_pkg::REG_STEER_LO, {junk[15:3], c.steer_lo});
		write_reg(stlc_pkg::REG_STEER_HI, {junk[18:6], c.steer_hi});
		write_reg(stlc_pkg::REG_RELEASE_BAND, {junk[13:0], c.release_band});
		write_reg(stlc_pkg::REG_CMD_FLOOR, {junk[31:19], c.cmd_floor});
		write_reg(stlc_pkg::REG_CMD_CEIL, {junk[28:16], c.cmd_ceil});
	endtask

	function automatic stlc_pkg::cfg_t random_config();
		stlc_pkg::cfg_t c;
		int   lo;
		int   hi;
		int   tl;
		int   th;
		int   swap;
		int   pick;
		c.motor_id   = $urandom_range(0, 1) ? 29'($urandom) : 29'($urandom_range(0, 2047));
		c.steer_zero = 16'($urandom);
		lo = int'($urandom_range(0, 40000)) - 20000;
		hi = lo + int'($urandom_range(0, 8000));
		if (hi > 32767)
			hi = 32767;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			swap = lo;
			lo   = hi;
			hi   = swap;
		end else if (pick == 1) begin
			lo = -32768;
			hi = 32767;
		end
		c.steer_lo     = lo[15:0];
		c.steer_hi     = hi[15:0];
		c.release_band = ($urandom_range(0, 9) < 7) ? 15'($urandom_range(0, 300))
		                                            : 15'($urandom);
		tl = int'($urandom_range(0, 65535)) - 32768;
		th = int'($urandom_range(0, 65535)) - 32768;
		// Keep the torque window ordered most of the time.
		if (tl > th && $urandom_range(0, 9) != 0) begin
			swap = tl;
			tl   = th;
			th   = swap;
		end
		c.cmd_floor = tl[15:0];
		c.cmd_ceil  = th[15:0];
		return c;
	endfunction

	// Mostly frames for our motor and torque requests; encoder updates land
	// near the angle bounds so the limit flag trips and releases often.
	function automatic stlc_pkg::item_t random_item();
		stlc_pkg::item_t            it;
		logic [stlc_pkg::WordW-1:0] enc;
		int pick;
		int bound;
		int hyst;
		int center;
		int off;
		it.action         = ($urandom_range(0, 99) < 45) ? stlc_pkg::ACTION_TX
		                                                 : stlc_pkg::ACTION_RX;
		it.frame_id       = ($urandom_range(0, 9) < 8) ? shadow_cfg.motor_id : 29'($urandom);
		it.frame_len      = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(8, 15))
		                                               : 4'($urandom_range(0, 7));
		it.frame_payload  = {$urandom, $urandom};
		it.torque_request = 16'($urandom);
		hyst   = shadow_cfg.release_band;
		center = shadow_cfg.steer_zero;
		bound  = $urandom_range(0, 1) ? int'(shadow_cfg.steer_lo) : int'(shadow_cfg.steer_hi);
		off    = int'($urandom_range(0, 2 * hyst + 100)) - hyst - 50;
		enc    = 16'(center - (bound + off));
		pick   = $urandom_range(0, 99);
		if (pick < 30) begin
			it.frame_payload[7:0] = stlc_pkg::OPCODE_READ_ENCODER;
			if ($urandom_range(0, 9) < 6)
				it.frame_payload[31:16] = enc;
		end else if (pick < 60) begin
			it.frame_payload[7:0] = (pick < 45) ? stlc_pkg::OPCODE_STATUS_REPLY
			                                    : stlc_pkg::OPCODE_TORQUE;
			if ($urandom_range(0, 9) < 6)
				it.frame_payload[63:48] = enc;
		end else if (pick < 75) begin
			it.frame_payload[7:0] = stlc_pkg::OPCODE_READ_STATUS1;
		end
		return it;
	endfunction

	// Reset configuration: rejects, every opcode, unknown opcodes, long frames.
	task automatic test_frame_parsing();
		logic [stlc_pkg::IdW-1:0] id;
		id = RESET_CFG.motor_id;
		sender_pacing   = 1'b1;
		receiver_pacing = 1'b1;
		send_frame(id + 29'd1, 4'd8,
			{48'hFFFF_FFFF_FFFF, 8'hFF, stlc_pkg::OPCODE_STATUS_REPLY});
		send_frame(id, 4'd7, {48'hFFFF_FFFF_FFFF, 8'hFF, stlc_pkg::OPCODE_STATUS_REPLY});
		send_frame(id, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(id, 4'd15, {32'h0, 16'h1234, 8'h00, stlc_pkg::OPCODE_READ_ENCODER});
		send_frame(id, 4'd8,
			{16'hFFFF, 16'h8000, 16'h7FFF, 8'h80, stlc_pkg::OPCODE_STATUS_REPLY});
		send_frame(id, 4'd9,
			{16'h0000, 16'h7FFF, 16'h8000, 8'h7F, stlc_pkg::OPCODE_TORQUE});
		send_frame(id, 4'd8, {8'h09, 48'hFFFF_FFFF_FFFF, stlc_pkg::OPCODE_READ_STATUS1});
		send_frame(id, 4'd8, {56'hFF_FFFF_FFFF_FFFF, 8'h00});
		send_frame(id, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(29'h1FFF_FFFF, 4'd8,
			{32'h0, 16'hABCD, 8'h00, stlc_pkg::OPCODE_READ_ENCODER});
		drain_requests();
	endtask

	// Sign flip and wrap, clamping, limit trip and release, inverted bounds.
	task automatic test_torque_command();
		stlc_pkg::cfg_t           c;
		logic [stlc_pkg::IdW-1:0] id;
		id = shadow_cfg.motor_id;
		send_frame(id, 4'd8, {32'h0, 16'h8000, 8'h00, stlc_pkg::OPCODE_READ_ENCODER});
		send_torque(16'sd0);
		send_torque(16'sd1);
		send_torque(-16'sd1);
		send_torque(16'sh7FFF);
		send_torque(16'sh8000);
		send_torque(16'sd2000);
		send_torque(-16'sd3000);
		// Park just past the upper bound: the flag trips and torque goes to zero.
		send_frame(id, 4'd8, {32'h0, 16'h0000, 8'h00, stlc_pkg::OPCODE_READ_ENCODER});
		send_torque(16'sd500);
		// Back inside the bound but within the hysteresis band: stay limited.
		send_frame(id, 4'd8, {32'h0, 16'd50, 8'h00, stlc_pkg::OPCODE_READ_ENCODER});
		send_torque(16'sd500);
		// Exactly the release distance inside: the flag clears.
		send_frame(id, 4'd8, {32'h0, 16'd101, 8'h00, stlc_pkg::OPCODE_READ_ENCODER});
		send_torque(-16'sd100);
		c           = RESET_CFG;
		c.cmd_floor = 16'sd100;
		c.cmd_ceil  = -16'sd100;
		c.steer_lo  = 16'sd100;
		c.steer_hi  = -16'sd100;
		apply_config(c);
		send_torque(16'sd0);
		drain_requests();
	endtask

	// Corner settings of every register, then a random one.
	task automatic test_register_extremes();
		stlc_pkg::cfg_t c;
		sender_pacing   = 1'b1;
		receiver_pacing = 1'b1;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: c = '{motor_id: '0, steer_zero: '0, steer_lo: 16'sh8000,
					steer_hi: 16'sh8000, release_band: '0, cmd_floor: 16'sh8000,
					cmd_ceil: 16'sh8000};
				1: c = '{motor_id: '1, steer_zero: '1, steer_lo: 16'sh7FFF,
					steer_hi: 16'sh7FFF, release_band: '1, cmd_floor: 16'sh7FFF,
					cmd_ceil: 16'sh7FFF};
				2: c = '{motor_id: RESET_CFG.motor_id, steer_zero: 16'h8000,
					steer_lo: -16'sd1, steer_hi: 16'sd1, release_band: 15'd1,
					cmd_floor: 16'sh8000, cmd_ceil: 16'sh7FFF};
				default: c = random_config();
			endcase
			apply_config(c);
			if (k == 3)
				write_reg(REG_UNUSED, 29'($urandom));
			repeat (60) send_item(random_item());
		end
		drain_requests();
	endtask

	// Hold the result side off long enough that the block fills and stops
	// taking requests, while the sender keeps offering back to back.
	task automatic test_output_backpressure();
		sender_pacing   = 1'b0;
		receiver_pacing = 1'b0;
		@(posedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		repeat (40) send_item(random_item());
		drain_requests();
	endtask

	// Random traffic in blocks, each with fresh settings and its own pacing mix.
	task automatic test_random_traffic();
		for (int blk = 0; blk < 12; blk++) begin
			apply_config((blk == 0) ? RESET_CFG : random_config());
			sender_pacing   = (blk % 3) != 0;
			receiver_pacing = (blk % 4) != 1;
			repeat (120) send_item(random_item());
		end
		drain_requests();
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		action          = stlc_pkg::ACTION_RX;
		frame_id        = '0;
		frame_len       = '0;
		frame_payload   = '0;
		torque_request  = '0;
		cfg_valid       = 1'b0;
		cfg_index       = stlc_pkg::REG_MOTOR_ID;
		cfg_data        = '0;
		sender_pacing   = 1'b0;
		receiver_pacing = 1'b0;
		hold_request    = 1'b0;
		stall_left      = 0;
		shadow_cfg      = RESET_CFG;
		motor_shadow    = '0;
		limit_shadow    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_frame_parsing();
		test_torque_command();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic();

		drain_requests();
		// Let any stray result show up before closing the books.
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatches++;
		end
		$display("run covered %0d requests: %0d frames taken, %0d torque commands held at zero",
			requests_taken, frames_taken, torque_zeroed);
		$display("%0d register writes, %0d results compared, %0d field mismatches",
			cfg_writes, results_checked, mismatches);
		if (mismatches == 0)
			$display("steer_torque_limiter_can_frames: match");
		else
			$display("steer_torque_limiter_can_frames: mismatch");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/stlc_pkg.sv
hw/rtl/stlc_cfg_regs.sv
hw/rtl/stlc_rx_status.sv
hw/rtl/stlc_torque.sv
hw/rtl/steer_torque_limiter_can_frames.sv
tb/steer_torque_limiter_can_frames_tb.sv
